// ===== rtl/int8_float_scaled_dot_product_top_defines.svh =====
// Assertion macros shared by the scaled dot product block.
`ifndef INT8_FLOAT_SCALED_DOT_PRODUCT_TOP_DEFINES_SVH
`define INT8_FLOAT_SCALED_DOT_PRODUCT_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk and off during reset.
`define ISDP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and off during reset.
`define ISDP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/isdp_pkg.sv =====
// Types, constants and helper functions of the scaled dot product block.
`timescale 1ns / 1ps

package isdp_pkg;

    localparam logic [31:0] F32_ZERO   = 32'h0000_0000;
    localparam logic [31:0] F32_ONE    = 32'h3F80_0000;
    localparam logic [31:0] F32_QNAN   = 32'h7FC0_0000;
    localparam int          MW         = 50;

    typedef enum logic {
        FOP_MUL,
        FOP_ADD
    } fop_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_GO,
        ST_MUL_WT,
        ST_ADD_GO,
        ST_ADD_WT,
        ST_SCL_GO,
        ST_SCL_WT,
        ST_OUT
    } state_t;

    // Unpacked operand: mant has hidden bit unless subnormal, exp is at least 1.
    typedef struct packed {
        logic        sign;
        logic [7:0]  exp;
        logic [23:0] mant;
        logic        is_nan;
        logic        is_inf;
        logic        is_zero;
    } unp_t;

    // Value in flight between the unit's stages: mant / 2^49 * 2^(exp - 127).
    typedef struct packed {
        logic               sign;
        logic               nan;
        logic               inf;
        logic signed [10:0] exp;
        logic [MW-1:0]      mant;
    } fstage_t;

    function automatic unp_t f32_unpack(input logic [31:0] f);
        unp_t u;
        u.sign    = f[31];
        u.is_nan  = (f[30:23] == 8'hFF) && (f[22:0] != 23'd0);
        u.is_inf  = (f[30:23] == 8'hFF) && (f[22:0] == 23'd0);
        u.is_zero = (f[30:0] == 31'd0);
        if (f[30:23] == 8'd0)
        begin
            u.exp  = 8'd1;
            u.mant = {1'b0, f[22:0]};
        end
        else
        begin
            u.exp  = f[30:23];
            u.mant = {1'b1, f[22:0]};
        end
        return u;
    endfunction

    // Exact conversion of a signed 8-bit integer to single precision.
    function automatic logic [31:0] int8_to_f32(input logic signed [7:0] w);
        logic [7:0]  mag;
        logic [2:0]  p;
        logic [23:0] m24;
        mag = w[7] ? 8'(-w) : 8'(w);
        p   = 3'd0;
        for (int i = 0; i < 8; i++)
        begin
            if (mag[i])
            begin
                p = 3'(i);
            end
        end
        m24 = {16'd0, mag} << (5'd23 - 5'(p));
        if (mag == 8'd0)
        begin
            return F32_ZERO;
        end
        return {w[7], 8'(8'd127 + 8'(p)), m24[22:0]};
    endfunction

endpackage

// ===== rtl/isdp_fpu.sv =====
// Three-stage single-precision multiply/add unit shared by every step of the sequence.
`timescale 1ns / 1ps

module isdp_fpu
    import isdp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  fop_t        op,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic        done,
    output logic [31:0] result
);

    unp_t          ua;
    unp_t          ub;
    fstage_t       sa_next;
    fstage_t       sa_reg;
    fstage_t       sb_next;
    fstage_t       sb_reg;
    logic [2:0]    vld_reg;
    logic [31:0]   res_next;
    logic [31:0]   res_reg;

    // Operand setup, alignment and the raw product or sum.
    always_comb
    begin
        unp_t          big;
        unp_t          sml;
        logic [7:0]    d;
        logic [5:0]    sh;
        logic [MW-1:0] bb;
        logic [MW-1:0] al;
        logic [MW-1:0] aa;
        logic [47:0]   prod;
        logic          lost;
        ua      = f32_unpack(a);
        ub      = f32_unpack(b);
        sa_next = '0;
        big     = ua;
        sml     = ub;
        d       = 8'd0;
        sh      = 6'd0;
        bb      = '0;
        al      = '0;
        aa      = '0;
        prod    = 48'd0;
        lost    = 1'b0;
        if (op == FOP_MUL)
        begin
            prod         = ua.mant * ub.mant;
            sa_next.sign = ua.sign ^ ub.sign;
            sa_next.mant = {1'b0, prod, 1'b0};
            sa_next.exp  = 11'($signed({3'd0, ua.exp})) + 11'($signed({3'd0, ub.exp}))
                           - 11'sd125;
            sa_next.nan  = ua.is_nan || ub.is_nan || (ua.is_inf && ub.is_zero)
                           || (ub.is_inf && ua.is_zero);
            sa_next.inf  = ua.is_inf || ub.is_inf;
        end
        else
        begin
            if ({ub.exp, ub.mant} > {ua.exp, ua.mant})
            begin
                big = ub;
                sml = ua;
            end
            d    = big.exp - sml.exp;
            sh   = (d > 8'd63) ? 6'd63 : d[5:0];
            bb   = {1'b0, sml.mant, 25'd0};
            al   = bb >> sh;
            lost = ((al << sh) != bb);
            al   = al | {{(MW-1){1'b0}}, lost};
            aa   = {1'b0, big.mant, 25'd0};
            sa_next.mant = (big.sign == sml.sign) ? (aa + al) : (aa - al);
            sa_next.exp  = 11'($signed({3'd0, big.exp})) + 11'sd1;
            sa_next.sign = big.sign;
            // An exact zero sum is negative only when both addends are.
            if (sa_next.mant == '0)
            begin
                sa_next.sign = ua.sign & ub.sign;
            end
            sa_next.nan = ua.is_nan || ub.is_nan
                          || (ua.is_inf && ub.is_inf && (ua.sign != ub.sign));
            sa_next.inf = ua.is_inf || ub.is_inf;
            if (ua.is_inf)
            begin
                sa_next.sign = ua.sign;
            end
            else if (ub.is_inf)
            begin
                sa_next.sign = ub.sign;
            end
        end
    end

    // Normalize: leading-one search and left shift.
    always_comb
    begin
        logic [5:0] lz;
        lz = 6'd0;
        for (int i = 0; i < MW; i++)
        begin
            if (sa_reg.mant[i])
            begin
                lz = 6'(MW - 1 - i);
            end
        end
        sb_next      = sa_reg;
        sb_next.mant = sa_reg.mant << lz;
        sb_next.exp  = sa_reg.exp - 11'($signed({5'd0, lz}));
    end

    // Denormalize if needed, round to nearest even and pack.
    always_comb
    begin
        logic [5:0]         sh;
        logic signed [10:0] dn;
        logic [MW-1:0]      mm;
        logic               lost;
        logic               g;
        logic               st;
        logic [7:0]         ef;
        logic [30:0]        mag;
        dn   = 11'sd1 - sb_reg.exp;
        sh   = 6'd0;
        ef   = 8'd0;
        if (sb_reg.exp >= 11'sd1)
        begin
            ef = sb_reg.exp[7:0];
        end
        else if (dn > 11'sd63)
        begin
            sh = 6'd63;
        end
        else
        begin
            sh = dn[5:0];
        end
        mm   = sb_reg.mant >> sh;
        lost = ((mm << sh) != sb_reg.mant);
        g    = mm[25];
        st   = (mm[24:0] != 25'd0) || lost;
        // A carry out of the fraction moves into the exponent field, up to infinity.
        mag  = {ef, mm[48:26]} + 31'(g & (st | mm[26]));
        if (sb_reg.nan)
        begin
            res_next = F32_QNAN;
        end
        else if (sb_reg.inf || (sb_reg.exp >= 11'sd255 && sb_reg.mant != '0))
        begin
            res_next = {sb_reg.sign, 8'hFF, 23'd0};
        end
        else if (sb_reg.mant == '0)
        begin
            res_next = {sb_reg.sign, 31'd0};
        end
        else
        begin
            res_next = {sb_reg.sign, mag};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 3'd0;
        end
        else
        begin
            vld_reg <= {vld_reg[1:0], start};
        end
    end

    always_ff @(posedge clk)
    begin
        sa_reg  <= sa_next;
        sb_reg  <= sb_next;
        res_reg <= res_next;
    end

    assign done   = vld_reg[2];
    assign result = res_reg;

endmodule

// ===== rtl/int8_float_scaled_dot_product_top.sv =====
// Top level: sequencer and state of the int8 x float scaled dot product.
//
//  Channel   Direction  Signals                    Content
//  s_axis    in         s_tvalid/s_tready/s_tdata  weight, activation; tlast = last_element
//  m_axis    out        m_tvalid/m_tready/m_tdata  dot_result
//  config    in         cfg_wr_en/cfg_wr_data      row_scale
//
// Each element goes through the shared unit twice (multiply, then add); a pass issues
// the operation and then waits for it through the unit's stages, and the next element
// is accepted only once its add is done. A last element adds one more pass for the
// scale and a step to load the output.
// Reset returns the scale to 1.0 and the running sum to +0.0.
// The output register holds a result while the next input is taken; only a second
// finished result waits for it to drain.
`timescale 1ns / 1ps
`include "int8_float_scaled_dot_product_top_defines.svh"

module int8_float_scaled_dot_product_top
    import isdp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [7:0] weight, [39:8] activation
    input  logic        s_tlast,   // last_element
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] dot_result
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data
);

    state_t      state_reg;
    state_t      state_next;
    logic [31:0] scale_reg;
    logic [31:0] sum_reg;
    logic [31:0] sum_next;
    logic [31:0] tmp_reg;
    logic [31:0] tmp_next;
    logic [7:0]  w_reg;
    logic [31:0] act_reg;
    logic        last_reg;
    logic        m_tvalid_reg;
    logic        m_tvalid_next;
    logic [31:0] m_tdata_reg;
    logic [31:0] m_tdata_next;
    logic        fpu_start;
    fop_t        fpu_op;
    logic [31:0] fpu_a;
    logic [31:0] fpu_b;
    logic        fpu_done;
    logic [31:0] fpu_res;
    logic        accept;

    isdp_fpu u_fpu (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (fpu_start),
        .op     (fpu_op),
        .a      (fpu_a),
        .b      (fpu_b),
        .done   (fpu_done),
        .result (fpu_res)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        state_next    = state_reg;
        sum_next      = sum_reg;
        tmp_next      = tmp_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        fpu_start     = 1'b0;
        fpu_op        = FOP_MUL;
        fpu_a         = int8_to_f32(w_reg);
        fpu_b         = act_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_MUL_GO;
                end
            end
            ST_MUL_GO:
            begin
                fpu_start  = 1'b1;
                state_next = ST_MUL_WT;
            end
            ST_MUL_WT:
            begin
                if (fpu_done)
                begin
                    tmp_next   = fpu_res;
                    state_next = ST_ADD_GO;
                end
            end
            ST_ADD_GO:
            begin
                fpu_start  = 1'b1;
                fpu_op     = FOP_ADD;
                fpu_a      = sum_reg;
                fpu_b      = tmp_reg;
                state_next = ST_ADD_WT;
            end
            ST_ADD_WT:
            begin
                if (fpu_done)
                begin
                    tmp_next = fpu_res;
                    if (last_reg)
                    begin
                        sum_next   = F32_ZERO;
                        state_next = ST_SCL_GO;
                    end
                    else
                    begin
                        sum_next   = fpu_res;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_SCL_GO:
            begin
                fpu_start  = 1'b1;
                fpu_a      = tmp_reg;
                fpu_b      = scale_reg;
                state_next = ST_SCL_WT;
            end
            ST_SCL_WT:
            begin
                if (fpu_done)
                begin
                    tmp_next   = fpu_res;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = tmp_reg;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            scale_reg    <= F32_ONE;
            sum_reg      <= F32_ZERO;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            sum_reg      <= sum_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr_en)
            begin
                scale_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tmp_reg     <= tmp_next;
        m_tdata_reg <= m_tdata_next;
        if (accept)
        begin
            w_reg    <= s_tdata[7:0];
            act_reg  <= s_tdata[39:8];
            last_reg <= s_tlast;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `ISDP_ASSERT_NEXT(a_busy_after_accept, accept, !s_tready, "input taken while busy")
    `ISDP_ASSERT_NOW(a_done_when_waiting, fpu_done,
        state_reg == ST_MUL_WT || state_reg == ST_ADD_WT || state_reg == ST_SCL_WT,
        "unit result arrived outside a wait state")
    `ISDP_ASSERT_NEXT(a_out_loads, state_reg == ST_OUT && (!m_tvalid_reg || m_tready),
        m_tvalid && state_reg == ST_IDLE, "finished result not loaded")

endmodule
